// File: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared constants and helpers for the seconds to calendar pipeline
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned EPOCH_YEAR    = 1970;
	localparam int unsigned EPOCH_WEEKDAY = 4;
	// day count of 2100-03-01, first day after the skipped gregorian feb 29
	localparam int unsigned DAY_2100_MAR1 = 47541;

	// day of year on which month m starts; leap years shift march onward by one
	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] s;
		case (m)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd59;
			4'd3:    s = 9'd90;
			4'd4:    s = 9'd120;
			4'd5:    s = 9'd151;
			4'd6:    s = 9'd181;
			4'd7:    s = 9'd212;
			4'd8:    s = 9'd243;
			4'd9:    s = 9'd273;
			4'd10:   s = 9'd304;
			4'd11:   s = 9'd334;
			default: s = 9'd0;
		endcase
		if (leap && (m >= 4'd2))
			s = s + 9'd1;
		return s;
	endfunction

endpackage

// File: hdl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts a 32-bit epoch second count into time of day, weekday and date
// ----------------------------------------------------------------------------
// usage:
//   input word: epoch_seconds on in_valid / in_stall
//   output word: second .. day_of_month on out_valid / out_stall
//   stage 1 splits seconds by 60 via reciprocal multiply
//   stage 2 splits minutes by 60, stage 3 splits hours by 24 and flags
//     day counts from 2100-03-01 on
//   stage 4 forms weekday from the day count (reciprocal multiply by 7) and
//     splits the day count into 4-year cycles (reciprocal multiply by 1461);
//     flagged days get one extra day, a phantom 2100-02-29, so every fourth
//     year can be treated as leap from here on
//   stage 5 picks the year inside the cycle, stage 6 finds the month by
//   comparing the day of year against the month start offsets
//   stage 7 is the output register
//   one word enters every cycle while not stalled
//   a stall at the output freezes the whole pipe; in_stall follows it
//   asynchronous reset clears all valid bits; payloads hold no reset
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
	import esc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [2:0]  weekday,
	output logic [11:0] calendar_year,
	output logic [3:0]  month_number,
	output logic [4:0]  day_of_month
);

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: seconds / 60
	logic [6:0]  v_q;
	logic [63:0] p1;
	logic [26:0] q1;
	logic [31:0] r1;
	logic [26:0] min_s1;
	logic [5:0]  sec_s1;
	assign p1 = epoch_seconds * 64'd2290649225; // 2^37/60 rounded up
	assign q1 = p1[63:37];
	assign r1 = epoch_seconds - q1 * 32'd60;
	always_ff @(posedge clk) if (adv) begin
		min_s1 <= q1;
		sec_s1 <= r1[5:0];
	end

	// stage 2: minutes / 60
	logic [54:0] p2;
	logic [20:0] q2;
	logic [26:0] r2;
	logic [20:0] hr_s2;
	logic [5:0]  sec_s2, min_s2;
	assign p2 = min_s1 * 28'd143165577; // 2^33/60 rounded up
	assign q2 = p2[53:33];
	assign r2 = min_s1 - q2 * 27'd60;
	always_ff @(posedge clk) if (adv) begin
		hr_s2  <= q2;
		min_s2 <= r2[5:0];
		sec_s2 <= sec_s1;
	end

	// stage 3: hours / 24
	logic [41:0] p3;
	logic [15:0] q3;
	logic [20:0] r3;
	logic [15:0] days_s3;
	logic        adj_s3;
	logic [4:0]  hr_s3;
	logic [5:0]  sec_s3, min_s3;
	assign p3 = hr_s2 * 21'd699051; // 2^24/24 rounded up
	assign q3 = p3[39:24];
	assign r3 = hr_s2 - q3 * 21'd24;
	always_ff @(posedge clk) if (adv) begin
		days_s3 <= q3;
		// 2100 is common: days from its march 1 on get a phantom feb 29
		adj_s3  <= (hr_s2 >= 21'(DAY_2100_MAR1 * 24));
		hr_s3   <= r3[4:0];
		min_s3  <= min_s2;
		sec_s3  <= sec_s2;
	end

	// stage 4: weekday and 4-year cycle split, days / 1461
	logic [16:0] dw;
	logic [33:0] p4;
	logic [16:0] q7;
	logic [16:0] r7;
	logic [15:0] days_adj;
	logic [31:0] p4b;
	logic [5:0]  cyc;
	logic [15:0] rc;
	logic [5:0]  cyc_s4;
	logic [10:0] rc_s4;
	logic [2:0]  wd_s4;
	logic [4:0]  hr_s4;
	logic [5:0]  sec_s4, min_s4;
	assign dw  = {1'b0, days_s3} + 17'(EPOCH_WEEKDAY);
	assign p4  = dw * 17'd74899; // 2^19/7 rounded up
	assign q7  = {4'b0000, p4[31:19]};
	assign r7  = dw - q7 * 17'd7;
	assign days_adj = days_s3 + {15'd0, adj_s3};
	assign p4b = days_adj * 16'd45934; // 2^26/1461 rounded up
	assign cyc = p4b[31:26];
	assign rc  = days_adj - 16'(cyc) * 16'd1461;
	always_ff @(posedge clk) if (adv) begin
		cyc_s4  <= cyc;
		rc_s4   <= rc[10:0];
		wd_s4   <= r7[2:0];
		hr_s4   <= hr_s3; min_s4 <= min_s3; sec_s4 <= sec_s3;
	end

	// stage 5: year within the cycle (1970 cycle: 365,365,366,365)
	logic [1:0]  yi;
	logic [10:0] yoff;
	logic [11:0] yb;
	logic [10:0] rdoy;
	logic [11:0] yr_s5;
	logic [8:0]  doy_s5;
	logic [2:0]  wd_s5;
	logic [4:0]  hr_s5;
	logic [5:0]  sec_s5, min_s5;
	always_comb begin
		if (rc_s4 < 11'd365)       begin yi = 2'd0; yoff = 11'd0;    end
		else if (rc_s4 < 11'd730)  begin yi = 2'd1; yoff = 11'd365;  end
		else if (rc_s4 < 11'd1096) begin yi = 2'd2; yoff = 11'd730;  end
		else                       begin yi = 2'd3; yoff = 11'd1096; end
		yb   = 12'(EPOCH_YEAR) + {4'd0, cyc_s4, 2'b00} + {10'd0, yi};
		rdoy = rc_s4 - yoff;
	end
	always_ff @(posedge clk) if (adv) begin
		yr_s5  <= yb;
		doy_s5 <= rdoy[8:0];
		wd_s5  <= wd_s4; hr_s5 <= hr_s4; min_s5 <= min_s4; sec_s5 <= sec_s4;
	end

	// stage 6: month from parallel compares against the month starts
	logic [3:0]  mo;
	logic [8:0]  mbase;
	logic [8:0]  dd;
	logic        lp;
	logic [3:0]  mo_s6;
	logic [4:0]  dom_s6;
	logic [11:0] yr_s6;
	logic [2:0]  wd_s6;
	logic [4:0]  hr_s6;
	logic [5:0]  sec_s6, min_s6;
	always_comb begin
		// every fourth year is leap here; 2100 carries the phantom feb 29
		lp    = (yr_s5[1:0] == 2'b00);
		mo    = 4'd0;
		mbase = 9'd0;
		for (int m = 1; m < 12; m++) begin
			if (doy_s5 >= month_start(4'(m), lp)) begin
				mo    = 4'(m);
				mbase = month_start(4'(m), lp);
			end
		end
		dd = doy_s5 - mbase;
	end
	always_ff @(posedge clk) if (adv) begin
		mo_s6  <= mo + 4'd1;
		dom_s6 <= dd[4:0] + 5'd1;
		yr_s6  <= yr_s5;
		wd_s6  <= wd_s5; hr_s6 <= hr_s5; min_s6 <= min_s5; sec_s6 <= sec_s5;
	end

	// stage 7: output register
	always_ff @(posedge clk) if (adv) begin
		second        <= sec_s6;
		minute        <= min_s6;
		hour          <= hr_s6;
		weekday       <= wd_s6;
		calendar_year <= yr_s6;
		month_number  <= mo_s6;
		day_of_month  <= dom_s6;
	end

	// valid bits travel alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[5:0], in_valid};
	end
	assign out_valid = v_q[6];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(calendar_year))
		else $error("output word changed under stall");
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to output stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month_number >= 4'd1 && month_number <= 4'd12 && weekday <= 3'd6)
		else $error("date field out of range");

endmodule

// File: test/epoch_seconds_to_calendar_tb.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// drives epoch second counts with random gaps and checks each calendar word
// against a behavioral date predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;
	import esc_pkg::*;

	// one calendar word as the block presents it
	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [2:0]  weekday;
		logic [11:0] calendar_year;
		logic [3:0]  month_number;
		logic [4:0]  day_of_month;
	} cal_word_t;

	// directed row: input, and a typed-in date where it is obvious
	typedef struct {
		logic [31:0] secs;
		bit          known;
		cal_word_t   date;
	} stim_row_t;

	localparam int N_RANDOM    = 1030;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [2:0]  weekday;
	logic [11:0] calendar_year;
	logic [3:0]  month_number;
	logic [4:0]  day_of_month;

	cal_word_t pending_dates[$];
	int        mismatch_count;
	int        cycle_count;
	bit        stim_done;

	epoch_seconds_to_calendar uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .epoch_seconds(epoch_seconds),
		.out_valid(out_valid), .out_stall(out_stall),
		.second(second), .minute(minute), .hour(hour), .weekday(weekday),
		.calendar_year(calendar_year), .month_number(month_number),
		.day_of_month(day_of_month)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// gregorian leap test on a full year number
	function automatic bit greg_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// date from epoch seconds: split time of day, then walk years and months
	function automatic cal_word_t calendar_of(input logic [31:0] secs);
		cal_word_t   w;
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned mon;
		int unsigned mlen;
		int unsigned ylen;
		int unsigned lens[12];
		lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		t = secs;
		w.second = 6'(t % 60);
		t = t / 60;
		w.minute = 6'(t % 60);
		t = t / 60;
		w.hour = 5'(t % 24);
		days = t / 24;
		w.weekday = 3'((days + 4) % 7);
		yr = 1970;
		ylen = greg_leap(yr) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			yr++;
			ylen = greg_leap(yr) ? 366 : 365;
		end
		mon = 0;
		while (mon < 11) begin
			mlen = (mon == 1 && greg_leap(yr)) ? 29 : lens[mon];
			if (days < mlen) break;
			days -= mlen;
			mon++;
		end
		w.calendar_year = 12'(yr);
		w.month_number = 4'(mon + 1);
		w.day_of_month = 5'(days + 1);
		return w;
	endfunction

	// random idle length: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random input: mix of full range and day boundaries
	function automatic logic [31:0] pick_seconds();
		int unsigned sel;
		int unsigned d;
		logic [31:0] base;
		sel = $urandom_range(0, 9);
		if (sel < 5) return $urandom;
		// day boundary near a random day, +/- a few seconds
		d = $urandom_range(0, 49710);
		base = d * 86400;
		if (sel < 8) return base + $urandom_range(0, 3) - (sel == 6 ? 2 : 0);
		return base + 86399;
	endfunction

	// push one word through the input handshake and log its expected date;
	// valid stays up between back to back words
	task automatic send_word(input logic [31:0] secs, input bit known, input cal_word_t date);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= secs;
		pending_dates.push_back(known ? date : calendar_of(secs));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// directed rows; dates typed in where they are obvious
	stim_row_t directed_rows[] = '{
		'{32'd0,          1'b1, '{6'd0, 6'd0, 5'd0, 3'd4, 12'd1970, 4'd1, 5'd1}},
		'{32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6, 3'd0, 12'd2106, 4'd2, 5'd7}},
		'{32'd59,         1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd86400,      1'b0, '0},
		'{32'd68169599,   1'b0, '0},  // end of leap 1972 feb 28
		'{32'd68256000,   1'b0, '0},  // 1972 mar 1
		'{32'd951782400,  1'b0, '0},  // 2000 feb 29
		'{32'd951868800,  1'b0, '0},
		'{32'd978307199,  1'b0, '0},  // last second of 2000
		'{32'd4107542399, 1'b0, '0},  // century 2100 feb 28 end
		'{32'd4107542400, 1'b0, '0},  // 2100 mar 1, no feb 29
		'{32'd4133980799, 1'b0, '0},  // end of 2100
		'{32'd2147483647, 1'b0, '0},
		'{32'h80000000,   1'b0, '0},
		'{32'h55555555,   1'b0, '0},
		'{32'hAAAAAAAA,   1'b0, '0},
		'{32'd1234567890, 1'b0, '0}
	};

	// stimulus: reset, directed table, then random words
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		epoch_seconds = '0;
		stim_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_word(directed_rows[i].secs, directed_rows[i].known, directed_rows[i].date);
		for (int i = 0; i < N_RANDOM; i++)
			send_word(pick_seconds(), 1'b0, '0);
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// output side: random stall, compare on each accepted word
	initial begin
		int        hold;
		cal_word_t got;
		cal_word_t want;
		out_stall = 1'b0;
		mismatch_count = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = '{second, minute, hour, weekday, calendar_year, month_number,
					day_of_month};
				if (pending_dates.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected word: %p", got);
				end else begin
					want = pending_dates.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			// stall stretches, with quiet phases between
			if (hold > 0) hold--;
			else hold = gap_len();
			out_stall <= (hold > 0);
		end
	end

	// end of run and watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (stim_done && pending_dates.size() == 0) begin
				repeat (DRAIN_WAIT) @(posedge clk);
				if (mismatch_count == 0)
					$display("Testbench completed without errors");
				else
					$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
